// File: rtl/core/rk4_pkg.sv
// rk4_pkg: shared constants and codes for the RK4 ODE step core.
// Used by the channel interfaces and by rk4_ode_step_core in rtl/core.
package rk4_pkg;

    // Fixed port widths
    localparam int DATA_W     = 32;
    localparam int INDEX_W    = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int SEL_W      = 2;

    // Slope sum is divided by this constant
    localparam int SLOPE_DIV  = 6;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ODE_SELECT  = 3'd0,
        REG_STEP_SIZE   = 3'd1,
        REG_START_TIME  = 3'd2,
        REG_START_VALUE = 3'd3,
        REG_STEP_LIMIT  = 3'd4
    } cfg_reg_t;

    // Right-hand side selection codes
    typedef enum logic [SEL_W-1:0] {
        ODE_T_MINUS_X  = 2'd0,
        ODE_X_OVER_1PT = 2'd1,
        ODE_T_PLUS_X   = 2'd2,
        ODE_RATIO      = 2'd3
    } ode_sel_t;

endpackage

// File: rtl/core/rk4_if.sv
// rk4_if: valid/ready channel interfaces of the RK4 ODE step core.
// Depends on rk4_pkg for the payload widths.
interface rk4_in_if;
    logic valid;
    logic ready;
    logic restart;
    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface rk4_out_if;
    logic                              valid;
    logic                              ready;
    logic [rk4_pkg::INDEX_W-1:0]       step_index;
    logic signed [rk4_pkg::DATA_W-1:0] time_after;
    logic signed [rk4_pkg::DATA_W-1:0] value_after;
    logic                              final_step;
    logic                              div_fault;
    logic                              overflow;
    modport source (output valid, output step_index, output time_after,
                    output value_after, output final_step, output div_fault,
                    output overflow, input ready);
    modport sink (input valid, input step_index, input time_after,
                  input value_after, input final_step, input div_fault,
                  input overflow, output ready);
endinterface

interface rk4_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rk4_pkg::CFG_ADDR_W-1:0] index;
    logic [rk4_pkg::DATA_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/rk4_mul.sv
// rk4_mul: bit-serial sign/magnitude multiplier, one multiplier bit per cycle,
// optional fraction shift and saturation to the word range. No dependencies.
module rk4_mul #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [W+1:0]     a_mag,
    input  logic [W+1:0]     b_mag,
    input  logic             neg,
    input  logic             frac,
    output logic             done,
    output logic [W-1:0]     result,
    output logic             ovf
);

    localparam int OW = W + 2;
    localparam int PW = 2 * OW;
    localparam int CW = $clog2(OW + 1);
    localparam logic [CW-1:0] LAST = CW'(OW - 1);
    localparam logic [PW-1:0] POS_LIM = PW'({1'b0, {(W-1){1'b1}}});

    logic          busy_reg;
    logic          fin_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [PW-1:0] acc_reg;
    logic [PW-1:0] mc_reg;
    logic [OW-1:0] mp_reg;
    logic          neg_reg;
    logic          frac_reg;
    logic [W-1:0]  result_reg;
    logic          ovf_reg;

    logic [PW-1:0] shifted;
    logic [PW-1:0] lim;
    logic          over;
    logic [W-1:0]  mag_c;

    // Final shift, saturation and sign
    always_comb
    begin
        shifted = frac_reg ? (acc_reg >> F) : acc_reg;
        lim     = POS_LIM + PW'(neg_reg);
        over    = shifted > lim;
        mag_c   = over ? lim[W-1:0] : shifted[W-1:0];
    end

    // Shift-and-add sequence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                acc_reg  <= '0;
                mc_reg   <= PW'(a_mag);
                mp_reg   <= b_mag;
                cnt_reg  <= '0;
                neg_reg  <= neg;
                frac_reg <= frac;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (mp_reg[0])
                begin
                    acc_reg <= acc_reg + mc_reg;
                end
                mc_reg  <= mc_reg << 1;
                mp_reg  <= mp_reg >> 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg    <= 1'b0;
                done_reg   <= 1'b1;
                result_reg <= neg_reg ? (~mag_c + 1'b1) : mag_c;
                ovf_reg    <= over;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;
    assign ovf    = ovf_reg;

endmodule

// File: rtl/core/rk4_div.sv
// rk4_div: restoring fixed-point divider, one quotient bit per cycle,
// quotient saturated to the word range. No dependencies.
module rk4_div #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [W-1:0]     num_mag,
    input  logic [W+F+3:0]   den,
    input  logic             neg,
    output logic             done,
    output logic [W-1:0]     result,
    output logic             ovf
);

    localparam int NW = W + F;
    localparam int DW = W + F + 4;
    localparam int CW = $clog2(NW);
    localparam logic [CW-1:0] LAST = CW'(NW - 1);
    localparam logic [NW-1:0] POS_LIM = NW'({1'b0, {(W-1){1'b1}}});

    logic          busy_reg;
    logic          fin_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] dvd_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [NW-1:0] q_reg;
    logic          neg_reg;
    logic [W-1:0]  result_reg;
    logic          ovf_reg;

    logic [DW:0]   rr;
    logic          ge;
    logic [DW:0]   diff;
    logic [NW-1:0] lim;
    logic          over;
    logic [W-1:0]  mag_c;

    // One restoring step and the final saturation
    always_comb
    begin
        rr    = {rem_reg, dvd_reg[NW-1]};
        ge    = rr >= {1'b0, den_reg};
        diff  = rr - {1'b0, den_reg};
        lim   = POS_LIM + NW'(neg_reg);
        over  = q_reg > lim;
        mag_c = over ? lim[W-1:0] : q_reg[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                dvd_reg  <= NW'(num_mag) << F;
                rem_reg  <= '0;
                q_reg    <= '0;
                den_reg  <= den;
                neg_reg  <= neg;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? diff[DW-1:0] : rr[DW-1:0];
                q_reg   <= {q_reg[NW-2:0], ge};
                dvd_reg <= dvd_reg << 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg    <= 1'b0;
                done_reg   <= 1'b1;
                result_reg <= neg_reg ? (~mag_c + 1'b1) : mag_c;
                ovf_reg    <= over;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;
    assign ovf    = ovf_reg;

endmodule

// File: rtl/core/rk4_ode_step_core.sv
// RK4 ODE step core: each input transfer advances x' = f(t, x) by one classical
// fourth-order Runge-Kutta step in saturating signed fixed point (WORD_BITS total,
// FRAC_BITS fraction; Q16.16 by default) and returns one result transfer. Depends
// on rk4_pkg, rk4_if, rk4_mul and rk4_div.
//
// The step runs on one bit-serial multiplier and one restoring divider, one bit
// per cycle each. A step takes six products and one to five quotients (one for
// ode_select 0 and 2; for 1 and 3, five unless a denominator is zero). One item
// is in work at a time; the next one is taken while the previous result still
// waits in the output register.
module rk4_ode_step_core #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    rk4_in_if.sink       step_in,
    rk4_out_if.source    step_out,
    rk4_cfg_if.sink      cfg
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int OW = W + 2;
    localparam int DW = W + F + 4;

    typedef logic signed [W-1:0] word_t;
    typedef struct packed {
        logic  o;
        word_t w;
    } sat_t;

    localparam word_t MAX_V = {1'b0, {(W-1){1'b1}}};
    localparam word_t MIN_V = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [63:0] MAX64 = 64'(MAX_V);
    localparam logic signed [63:0] MIN64 = 64'(MIN_V);
    localparam logic  ONE_SAT = (F > W - 2);
    localparam word_t ONE_VAL = ONE_SAT ? MAX_V : ({{(W-1){1'b0}}, 1'b1} << F);
    localparam logic [DW-1:0] SIX_DEN = DW'(rk4_pkg::SLOPE_DIV) << F;

    // Saturating add and subtract
    function automatic sat_t sat_add(word_t a, word_t b);
        logic signed [W:0] s;
        sat_t r;
        s = {a[W-1], a} + {b[W-1], b};
        r.o = s[W] != s[W-1];
        r.w = r.o ? (s[W] ? MIN_V : MAX_V) : s[W-1:0];
        return r;
    endfunction

    function automatic sat_t sat_sub(word_t a, word_t b);
        logic signed [W:0] s;
        sat_t r;
        s = {a[W-1], a} - {b[W-1], b};
        r.o = s[W] != s[W-1];
        r.w = r.o ? (s[W] ? MIN_V : MAX_V) : s[W-1:0];
        return r;
    endfunction

    // Halve, truncating toward zero
    function automatic word_t half_of(word_t a);
        word_t t;
        t = a + {{(W-1){1'b0}}, a[W-1]};
        return {t[W-1], t[W-1:1]};
    endfunction

    function automatic logic [W-1:0] mag(word_t a);
        return a[W-1] ? (~a + 1'b1) : a;
    endfunction

    // Register write value: sign-extend 32 bits, clamp to the word
    function automatic word_t reg_value(logic [rk4_pkg::DATA_W-1:0] v);
        logic signed [63:0] e;
        e = 64'(signed'(v));
        if (e > MAX64)
        begin
            e = MAX64;
        end
        else if (e < MIN64)
        begin
            e = MIN64;
        end
        return e[W-1:0];
    endfunction

    function automatic logic [rk4_pkg::DATA_W-1:0] to_out(word_t v);
        logic signed [63:0] e;
        e = 64'(v);
        return e[rk4_pkg::DATA_W-1:0];
    endfunction

    localparam word_t H_RESET = reg_value(32'h0001_0000);

    typedef enum logic [3:0] {
        S_IDLE, S_TMUL0, S_TMUL1, S_PREP, S_XARG, S_RHS, S_DIV,
        S_KMUL, S_KMUL_W, S_SUMA, S_SUMB, S_INC, S_OUT
    } state_t;

    state_t state_reg;

    // Configuration
    logic [rk4_pkg::SEL_W-1:0]   sel_reg;
    word_t                       h_reg;
    word_t                       t0_reg;
    word_t                       x0_reg;
    logic [rk4_pkg::INDEX_W-1:0] limit_reg;

    // Step state and working values
    word_t                       x_reg;
    logic [rk4_pkg::INDEX_W-1:0] cnt_reg;
    word_t                       t_reg;
    word_t                       tm_reg;
    word_t                       te_reg;
    word_t                       ta_reg;
    word_t                       k_reg [4];
    logic [1:0]                  stage_reg;
    word_t                       xa_reg;
    word_t                       targ_reg;
    word_t                       f_reg;
    word_t                       s12_reg;
    word_t                       s23_reg;
    word_t                       s34_reg;
    logic                        ovf_reg;
    logic                        divf_reg;

    // Arithmetic unit requests
    logic          mul_go_reg;
    logic [OW-1:0] mul_a_reg;
    logic [OW-1:0] mul_b_reg;
    logic          mul_neg_reg;
    logic          mul_frac_reg;
    logic          div_go_reg;
    logic [W-1:0]  div_num_reg;
    logic [DW-1:0] div_den_reg;
    logic          div_neg_reg;

    // Output register
    logic                        out_valid_reg;
    logic [rk4_pkg::INDEX_W-1:0] out_idx_reg;
    logic [rk4_pkg::DATA_W-1:0]  out_time_reg;
    logic [rk4_pkg::DATA_W-1:0]  out_value_reg;
    logic                        out_final_reg;
    logic                        out_divf_reg;
    logic                        out_ovf_reg;

    logic         mul_done;
    logic [W-1:0] mul_res;
    logic         mul_ovf;
    logic         div_done;
    logic [W-1:0] div_res;
    logic         div_ovf;

    sat_t  ts_c, tm_c, te_c, xa_c, dsub_c, dadd_c, done_c;
    sat_t  a12_c, a23_c, a34_c, sab_c, sum_c, xnew_c;
    word_t targ_c, kprev_c, num_c, den_c;
    logic  rhs_ovf_c;

    rk4_mul #(.W(W), .F(F)) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (mul_go_reg),
        .a_mag  (mul_a_reg),
        .b_mag  (mul_b_reg),
        .neg    (mul_neg_reg),
        .frac   (mul_frac_reg),
        .done   (mul_done),
        .result (mul_res),
        .ovf    (mul_ovf)
    );

    rk4_div #(.W(W), .F(F)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (div_go_reg),
        .num_mag (div_num_reg),
        .den     (div_den_reg),
        .neg     (div_neg_reg),
        .done    (div_done),
        .result  (div_res),
        .ovf     (div_ovf)
    );

    // Datapath around the serial units
    always_comb
    begin
        ts_c    = sat_add(t0_reg, word_t'(mul_res));
        tm_c    = sat_add(t_reg, half_of(h_reg));
        te_c    = sat_add(t_reg, h_reg);
        kprev_c = k_reg[stage_reg - 2'd1];
        xa_c    = sat_add(x_reg, (stage_reg == 2'd3) ? kprev_c : half_of(kprev_c));
        case (stage_reg)
            2'd0:    targ_c = t_reg;
            2'd3:    targ_c = te_reg;
            default: targ_c = tm_reg;
        endcase
        dsub_c  = sat_sub(targ_reg, xa_reg);
        dadd_c  = sat_add(targ_reg, xa_reg);
        done_c  = sat_add(ONE_VAL, targ_reg);
        case (rk4_pkg::ode_sel_t'(sel_reg))
            rk4_pkg::ODE_T_MINUS_X:
            begin
                num_c     = dsub_c.w;
                den_c     = done_c.w;
                rhs_ovf_c = dsub_c.o;
            end
            rk4_pkg::ODE_X_OVER_1PT:
            begin
                num_c     = xa_reg;
                den_c     = done_c.w;
                rhs_ovf_c = done_c.o | ONE_SAT;
            end
            rk4_pkg::ODE_T_PLUS_X:
            begin
                num_c     = dadd_c.w;
                den_c     = done_c.w;
                rhs_ovf_c = dadd_c.o;
            end
            default:
            begin
                num_c     = dsub_c.w;
                den_c     = dadd_c.w;
                rhs_ovf_c = dsub_c.o | dadd_c.o;
            end
        endcase
        a12_c  = sat_add(k_reg[0], k_reg[1]);
        a23_c  = sat_add(k_reg[1], k_reg[2]);
        a34_c  = sat_add(k_reg[2], k_reg[3]);
        sab_c  = sat_add(s12_reg, s23_reg);
        sum_c  = sat_add(sab_c.w, s34_reg);
        xnew_c = sat_add(x_reg, word_t'(div_res));
    end

    // Sequencer, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= '0;
            h_reg         <= H_RESET;
            t0_reg        <= '0;
            x0_reg        <= '0;
            limit_reg     <= 16'd1;
            x_reg         <= '0;
            cnt_reg       <= '0;
            stage_reg     <= '0;
            ovf_reg       <= 1'b0;
            divf_reg      <= 1'b0;
            mul_go_reg    <= 1'b0;
            div_go_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_go_reg <= 1'b0;
            div_go_reg <= 1'b0;
            if (out_valid_reg && step_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg.valid)
            begin
                case (rk4_pkg::cfg_reg_t'(cfg.index))
                    rk4_pkg::REG_ODE_SELECT:  sel_reg   <= cfg.data[rk4_pkg::SEL_W-1:0];
                    rk4_pkg::REG_STEP_SIZE:   h_reg     <= reg_value(cfg.data);
                    rk4_pkg::REG_START_TIME:  t0_reg    <= reg_value(cfg.data);
                    rk4_pkg::REG_START_VALUE: x0_reg    <= reg_value(cfg.data);
                    rk4_pkg::REG_STEP_LIMIT:  limit_reg <= cfg.data[rk4_pkg::INDEX_W-1:0];
                    default: ;
                endcase
            end

            case (state_reg)
                // Take an item, start count * h
                S_IDLE:
                begin
                    if (step_in.valid)
                    begin
                        ovf_reg      <= 1'b0;
                        divf_reg     <= 1'b0;
                        if (step_in.restart)
                        begin
                            x_reg   <= x0_reg;
                            cnt_reg <= '0;
                        end
                        mul_a_reg    <= step_in.restart ? '0 : OW'(cnt_reg);
                        mul_b_reg    <= OW'(mag(h_reg));
                        mul_neg_reg  <= h_reg[W-1];
                        mul_frac_reg <= 1'b0;
                        mul_go_reg   <= 1'b1;
                        state_reg    <= S_TMUL0;
                    end
                end
                // t, then start (count + 1) * h
                S_TMUL0:
                begin
                    if (mul_done)
                    begin
                        t_reg      <= ts_c.w;
                        ovf_reg    <= ovf_reg | mul_ovf | ts_c.o;
                        mul_a_reg  <= OW'({1'b0, cnt_reg} + 17'd1);
                        mul_go_reg <= 1'b1;
                        state_reg  <= S_TMUL1;
                    end
                end
                S_TMUL1:
                begin
                    if (mul_done)
                    begin
                        ta_reg    <= ts_c.w;
                        ovf_reg   <= ovf_reg | mul_ovf | ts_c.o;
                        state_reg <= S_PREP;
                    end
                end
                // Midpoint and end times
                S_PREP:
                begin
                    tm_reg    <= tm_c.w;
                    te_reg    <= te_c.w;
                    ovf_reg   <= ovf_reg | tm_c.o | te_c.o;
                    stage_reg <= '0;
                    state_reg <= S_XARG;
                end
                // Arguments of this stage's f(t, x)
                S_XARG:
                begin
                    targ_reg <= targ_c;
                    if (stage_reg == 2'd0)
                    begin
                        xa_reg <= x_reg;
                    end
                    else
                    begin
                        xa_reg  <= xa_c.w;
                        ovf_reg <= ovf_reg | xa_c.o;
                    end
                    state_reg <= S_RHS;
                end
                // Right-hand side, direct or through the divider
                S_RHS:
                begin
                    ovf_reg <= ovf_reg | rhs_ovf_c;
                    if (sel_reg == rk4_pkg::ODE_T_MINUS_X || sel_reg == rk4_pkg::ODE_T_PLUS_X)
                    begin
                        f_reg     <= num_c;
                        state_reg <= S_KMUL;
                    end
                    else if (den_c == '0)
                    begin
                        f_reg     <= num_c[W-1] ? MIN_V : MAX_V;
                        divf_reg  <= 1'b1;
                        state_reg <= S_KMUL;
                    end
                    else
                    begin
                        div_num_reg <= mag(num_c);
                        div_den_reg <= DW'(mag(den_c));
                        div_neg_reg <= num_c[W-1] ^ den_c[W-1];
                        div_go_reg  <= 1'b1;
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        f_reg     <= div_res;
                        ovf_reg   <= ovf_reg | div_ovf;
                        state_reg <= S_KMUL;
                    end
                end
                // k = h * f
                S_KMUL:
                begin
                    mul_a_reg    <= OW'(mag(h_reg));
                    mul_b_reg    <= OW'(mag(f_reg));
                    mul_neg_reg  <= h_reg[W-1] ^ f_reg[W-1];
                    mul_frac_reg <= 1'b1;
                    mul_go_reg   <= 1'b1;
                    state_reg    <= S_KMUL_W;
                end
                S_KMUL_W:
                begin
                    if (mul_done)
                    begin
                        k_reg[stage_reg] <= mul_res;
                        ovf_reg          <= ovf_reg | mul_ovf;
                        stage_reg        <= stage_reg + 2'd1;
                        state_reg        <= (stage_reg == 2'd3) ? S_SUMA : S_XARG;
                    end
                end
                // k1 + 2 k2 + 2 k3 + k4, pairwise
                S_SUMA:
                begin
                    s12_reg   <= a12_c.w;
                    s23_reg   <= a23_c.w;
                    s34_reg   <= a34_c.w;
                    ovf_reg   <= ovf_reg | a12_c.o | a23_c.o | a34_c.o;
                    state_reg <= S_SUMB;
                end
                S_SUMB:
                begin
                    ovf_reg     <= ovf_reg | sab_c.o | sum_c.o;
                    div_num_reg <= mag(sum_c.w);
                    div_den_reg <= SIX_DEN;
                    div_neg_reg <= sum_c.w[W-1];
                    div_go_reg  <= 1'b1;
                    state_reg   <= S_INC;
                end
                // x += sum / 6
                S_INC:
                begin
                    if (div_done)
                    begin
                        x_reg     <= xnew_c.w;
                        cnt_reg   <= cnt_reg + 1'b1;
                        ovf_reg   <= ovf_reg | div_ovf | xnew_c.o;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || step_out.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_idx_reg   <= cnt_reg;
                        out_time_reg  <= to_out(ta_reg);
                        out_value_reg <= to_out(x_reg);
                        out_final_reg <= cnt_reg == limit_reg;
                        out_divf_reg  <= divf_reg;
                        out_ovf_reg   <= ovf_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign step_in.ready        = state_reg == S_IDLE;
    assign cfg.ready            = 1'b1;
    assign step_out.valid       = out_valid_reg;
    assign step_out.step_index  = out_idx_reg;
    assign step_out.time_after  = out_time_reg;
    assign step_out.value_after = out_value_reg;
    assign step_out.final_step  = out_final_reg;
    assign step_out.div_fault   = out_divf_reg;
    assign step_out.overflow    = out_ovf_reg;

endmodule
